@@ hdl/fwd_pkg.sv @@
// Shared types, codes and constants of the frame word deframer.
package fwd_pkg;

    localparam int SAMPLES_PER_WORD = 6;
    localparam int SAMPLE_BITS      = 10;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_WINDOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_TO_TIMESTAMP = 1'b1;

    localparam logic [15:0] TICKS_RESET = 16'd1024;
    localparam logic [15:0] SCALE_RESET = 16'd1;

    // Reciprocal of six scaled by 2^14; exact for dividends below 2048.
    localparam logic [11:0] DIV6_RECIP = 12'd2731;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_TRAILER = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_HEADER,
        ST_STAMP,
        ST_DATA,
        ST_BAD,
        ST_SAMPLE,
        ST_MUL1,
        ST_MUL2,
        ST_ADD1,
        ST_ADD2,
        ST_TRAILER
    } state_t;

    typedef struct packed {
        logic  take_byte;
        logic  latch_header;
        logic  latch_stamp;
        logic  latch_data;
        logic  pop_sample;
        logic  mul_first;
        logic  mul_second;
        logic  add_first;
        logic  add_second;
        kind_t out_kind;
        logic  out_last;
    } cmd_t;

    typedef struct packed {
        logic word_last;
        logic header_mark;
        logic no_samples;
        logic words_zero;
        logic words_one;
        logic sample_last;
    } status_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [9:0]  sample_value;
        logic [15:0] board_number;
        logic [63:0] frame_timestamp;
        logic        parity_ok;
        logic        count_mismatch;
        logic        last_of_run;
    } result_t;

endpackage

@@ hdl/fwd_in_if.sv @@
// Byte stream channel: valid/ready handshake carrying one byte.
interface fwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

@@ hdl/fwd_out_if.sv @@
// Result channel: valid/ready handshake carrying one result record.
interface fwd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [9:0]  sample_value;
    logic [15:0] board_number;
    logic [63:0] frame_timestamp;
    logic        parity_ok;
    logic        count_mismatch;
    logic        last_of_run;

    modport source (
        output valid, output record_kind, output sample_value, output board_number,
        output frame_timestamp, output parity_ok, output count_mismatch,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input record_kind, input sample_value, input board_number,
        input frame_timestamp, input parity_ok, input count_mismatch,
        input last_of_run, output ready
    );
endinterface

@@ hdl/fwd_controller.sv @@
// Frame sequencing state machine of the deframer.
module fwd_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  fwd_pkg::status_t status,
    output fwd_pkg::cmd_t    cmd
);

    fwd_pkg::state_t state_reg;
    fwd_pkg::state_t state_next;
    logic            take;

    // Open the byte stream only while a word is being collected.
    assign in_ready = (state_reg == fwd_pkg::ST_HEADER) || (state_reg == fwd_pkg::ST_STAMP)
                      || (state_reg == fwd_pkg::ST_DATA);
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwd_pkg::ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fwd_pkg::ST_HEADER:
            begin
                if (take && status.word_last)
                begin
                    state_next = status.header_mark ? fwd_pkg::ST_STAMP : fwd_pkg::ST_BAD;
                end
            end
            fwd_pkg::ST_STAMP:
            begin
                if (take && status.word_last)
                begin
                    state_next = status.words_zero ? fwd_pkg::ST_MUL1 : fwd_pkg::ST_DATA;
                end
            end
            fwd_pkg::ST_DATA:
            begin
                if (take && status.word_last)
                begin
                    if (!status.no_samples)
                    begin
                        state_next = fwd_pkg::ST_SAMPLE;
                    end
                    else if (status.words_one)
                    begin
                        state_next = fwd_pkg::ST_MUL1;
                    end
                end
            end
            fwd_pkg::ST_SAMPLE:
            begin
                if (out_ready && status.sample_last)
                begin
                    state_next = status.words_zero ? fwd_pkg::ST_MUL1 : fwd_pkg::ST_DATA;
                end
            end
            fwd_pkg::ST_BAD,
            fwd_pkg::ST_TRAILER:
            begin
                if (out_ready)
                begin
                    state_next = fwd_pkg::ST_HEADER;
                end
            end
            fwd_pkg::ST_MUL1: state_next = fwd_pkg::ST_MUL2;
            fwd_pkg::ST_MUL2: state_next = fwd_pkg::ST_ADD1;
            fwd_pkg::ST_ADD1: state_next = fwd_pkg::ST_ADD2;
            fwd_pkg::ST_ADD2: state_next = fwd_pkg::ST_TRAILER;
            default:          state_next = fwd_pkg::ST_HEADER;
        endcase
    end

    always_comb
    begin
        out_valid        = 1'b0;
        cmd              = '0;
        cmd.out_kind     = fwd_pkg::KIND_SAMPLE;
        case (state_reg)
            fwd_pkg::ST_HEADER:
            begin
                cmd.latch_header = take && status.word_last && status.header_mark;
            end
            fwd_pkg::ST_STAMP:
            begin
                cmd.latch_stamp = take && status.word_last;
            end
            fwd_pkg::ST_DATA:
            begin
                cmd.latch_data = take && status.word_last;
            end
            fwd_pkg::ST_BAD:
            begin
                out_valid    = 1'b1;
                cmd.out_kind = fwd_pkg::KIND_BAD;
                cmd.out_last = 1'b1;
            end
            fwd_pkg::ST_SAMPLE:
            begin
                out_valid      = 1'b1;
                cmd.out_kind   = fwd_pkg::KIND_SAMPLE;
                cmd.pop_sample = out_ready;
                // last_of_run marks the last sample of each word but the final one; a trailer follows the final word
                cmd.out_last   = status.sample_last && !status.words_zero;
            end
            fwd_pkg::ST_MUL1: cmd.mul_first  = 1'b1;
            fwd_pkg::ST_MUL2: cmd.mul_second = 1'b1;
            fwd_pkg::ST_ADD1: cmd.add_first  = 1'b1;
            fwd_pkg::ST_ADD2: cmd.add_second = 1'b1;
            fwd_pkg::ST_TRAILER:
            begin
                out_valid    = 1'b1;
                cmd.out_kind = fwd_pkg::KIND_TRAILER;
                cmd.out_last = 1'b1;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
        cmd.take_byte = take;
    end

endmodule

@@ hdl/fwd_datapath.sv @@
// Word assembly, header fields, sample unpacking and timestamp arithmetic.
module fwd_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fwd_pkg::cmd_t                    cmd,
    output fwd_pkg::status_t                 status,
    input  logic [7:0]                       in_byte,
    input  logic                             cfg_we,
    input  logic [fwd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fwd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fwd_pkg::result_t                 result
);

    // control state
    logic [55:0] word_shift_reg,  word_shift_next;
    logic [2:0]  byte_index_reg,  byte_index_next;
    logic [7:0]  words_left_reg,  words_left_next;
    logic [10:0] emitted_reg,     emitted_next;
    logic [2:0]  sample_cnt_reg,  sample_cnt_next;
    logic [15:0] ticks_reg,       ticks_next;
    logic [15:0] scale_reg,       scale_next;
    // payload
    logic [15:0] board_reg,       board_next;
    logic [19:0] window_reg,      window_next;
    logic [9:0]  sindex_reg,      sindex_next;
    logic [9:0]  clusters_reg,    clusters_next;
    logic        parity_reg,      parity_next;
    logic [63:0] base_reg,        base_next;
    logic [59:0] sample_shift_reg, sample_shift_next;
    logic [35:0] prod_wt_reg,     prod_wt_next;
    logic [25:0] prod_si_reg,     prod_si_next;
    logic [51:0] prod_full_reg,   prod_full_next;
    logic [63:0] stamp_reg,       stamp_next;

    logic [63:0] word;
    logic [2:0]  pad;
    logic [2:0]  n_new;
    logic [10:0] clusters_round;
    logic [22:0] div6_prod;

    assign word           = {word_shift_reg, in_byte};
    assign pad            = word[62:60];
    assign n_new          = (pad <= 3'(fwd_pkg::SAMPLES_PER_WORD))
                            ? 3'(fwd_pkg::SAMPLES_PER_WORD) - pad : 3'd0;
    assign clusters_round = {1'b0, word[57:48]} + 11'(fwd_pkg::SAMPLES_PER_WORD - 1);
    assign div6_prod      = {12'd0, clusters_round} * {11'd0, fwd_pkg::DIV6_RECIP};

    assign status.word_last   = (byte_index_reg == 3'd7);
    assign status.header_mark = word_shift_reg[55];
    assign status.no_samples  = (n_new == 3'd0);
    assign status.words_zero  = (words_left_reg == 8'd0);
    assign status.words_one   = (words_left_reg == 8'd1);
    assign status.sample_last = (sample_cnt_reg == 3'd1);

    always_comb
    begin
        word_shift_next   = word_shift_reg;
        byte_index_next   = byte_index_reg;
        words_left_next   = words_left_reg;
        emitted_next      = emitted_reg;
        sample_cnt_next   = sample_cnt_reg;
        ticks_next        = ticks_reg;
        scale_next        = scale_reg;
        board_next        = board_reg;
        window_next       = window_reg;
        sindex_next       = sindex_reg;
        clusters_next     = clusters_reg;
        parity_next       = parity_reg;
        base_next         = base_reg;
        sample_shift_next = sample_shift_reg;
        prod_wt_next      = prod_wt_reg;
        prod_si_next      = prod_si_reg;
        prod_full_next    = prod_full_reg;
        stamp_next        = stamp_reg;

        if (cfg_we)
        begin
            if (cfg_index == fwd_pkg::CFG_TICKS_PER_WINDOW)
            begin
                ticks_next = cfg_data;
            end
            if (cfg_index == fwd_pkg::CFG_TICK_TO_TIMESTAMP)
            begin
                scale_next = cfg_data;
            end
        end

        if (cmd.take_byte)
        begin
            if (byte_index_reg == 3'd7)
            begin
                word_shift_next = '0;
                byte_index_next = 3'd0;
            end
            else
            begin
                word_shift_next = {word_shift_reg[47:0], in_byte};
                byte_index_next = byte_index_reg + 3'd1;
            end
        end

        if (cmd.latch_header)
        begin
            sindex_next     = word[16:7];
            window_next     = word[36:17];
            clusters_next   = word[57:48];
            board_next      = {word[62:58], word[47:37]};
            parity_next     = ((^word) == word[6]);
            words_left_next = div6_prod[21:14];
            emitted_next    = 11'd0;
        end

        if (cmd.latch_stamp)
        begin
            base_next = word;
        end

        if (cmd.latch_data)
        begin
            sample_shift_next = word[59:0];
            sample_cnt_next   = n_new;
            emitted_next      = emitted_reg + {8'd0, n_new};
            words_left_next   = words_left_reg - 8'd1;
        end

        if (cmd.pop_sample)
        begin
            sample_shift_next = sample_shift_reg << fwd_pkg::SAMPLE_BITS;
            sample_cnt_next   = sample_cnt_reg - 3'd1;
        end

        // timestamp: window*ticks and sample*scale, then *scale, then two adds
        if (cmd.mul_first)
        begin
            prod_wt_next = {16'd0, window_reg} * {20'd0, ticks_reg};
            prod_si_next = {16'd0, sindex_reg} * {10'd0, scale_reg};
        end
        if (cmd.mul_second)
        begin
            prod_full_next = {16'd0, prod_wt_reg} * {36'd0, scale_reg};
        end
        if (cmd.add_first)
        begin
            stamp_next = base_reg + {12'd0, prod_full_reg};
        end
        if (cmd.add_second)
        begin
            stamp_next = stamp_reg + {38'd0, prod_si_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_shift_reg <= '0;
            byte_index_reg <= '0;
            words_left_reg <= '0;
            emitted_reg    <= '0;
            sample_cnt_reg <= '0;
            ticks_reg      <= fwd_pkg::TICKS_RESET;
            scale_reg      <= fwd_pkg::SCALE_RESET;
        end
        else
        begin
            word_shift_reg <= word_shift_next;
            byte_index_reg <= byte_index_next;
            words_left_reg <= words_left_next;
            emitted_reg    <= emitted_next;
            sample_cnt_reg <= sample_cnt_next;
            ticks_reg      <= ticks_next;
            scale_reg      <= scale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        board_reg        <= board_next;
        window_reg       <= window_next;
        sindex_reg       <= sindex_next;
        clusters_reg     <= clusters_next;
        parity_reg       <= parity_next;
        base_reg         <= base_next;
        sample_shift_reg <= sample_shift_next;
        prod_wt_reg      <= prod_wt_next;
        prod_si_reg      <= prod_si_next;
        prod_full_reg    <= prod_full_next;
        stamp_reg        <= stamp_next;
    end

    always_comb
    begin
        result             = '0;
        result.record_kind = cmd.out_kind;
        result.last_of_run = cmd.out_last;
        case (cmd.out_kind)
            fwd_pkg::KIND_SAMPLE:
            begin
                result.sample_value = sample_shift_reg[59:50];
                result.board_number = board_reg;
            end
            fwd_pkg::KIND_TRAILER:
            begin
                result.board_number    = board_reg;
                result.frame_timestamp = stamp_reg;
                result.parity_ok       = parity_reg;
                result.count_mismatch  = (emitted_reg != {1'b0, clusters_reg});
            end
            default:
            begin
                result.board_number = 16'd0;
            end
        endcase
    end

endmodule

@@ hdl/frame_word_deframer_top.sv @@
// Top level of the frame word deframer: byte stream in, sample and trailer records out.
// Throughput: one byte per cycle while a word is collected; one record per ready cycle.
// Latency: a sample or bad-word record appears the cycle after the word's last byte; the
//   trailer follows its trigger through two multiply and two add steps, then the record.
// Input is held off while records of the current word are pending or the trailer computes.
// Reset (rst_n, async, active low): expect a header, clear counters, ticks 1024, scale 1.
module frame_word_deframer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    fwd_in_if.sink                         in_ch,
    fwd_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [fwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fwd_pkg::CFG_DATA_W-1:0] cfg_data
);

    fwd_pkg::cmd_t    cmd;
    fwd_pkg::status_t status;
    fwd_pkg::result_t result;
    logic             in_ready;
    logic             out_valid;

    // Sequence each frame: header, timestamp, data words, trailer.
    fwd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Assemble words, keep header fields, unpack samples and build the timestamp.
    fwd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (in_ch.in_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    assign in_ch.ready = in_ready;

    // Drive the result channel; payload is combinational from datapath registers and cmd.
    assign out_ch.valid           = out_valid;
    assign out_ch.record_kind     = result.record_kind;
    assign out_ch.sample_value    = result.sample_value;
    assign out_ch.board_number    = result.board_number;
    assign out_ch.frame_timestamp = result.frame_timestamp;
    assign out_ch.parity_ok       = result.parity_ok;
    assign out_ch.count_mismatch  = result.count_mismatch;
    assign out_ch.last_of_run     = result.last_of_run;

endmodule

@@ hdl/fwd_checker.sv @@
// Port-level checker of the deframer and its bind to the top level.
module fwd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  record_kind,
    input logic [15:0] board_number,
    input logic [63:0] frame_timestamp,
    input logic        parity_ok,
    input logic        count_mismatch,
    input logic        last_of_run
);

    // A pending record always holds off the byte stream.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("byte stream open while a record is pending");

    // A stalled record holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_kind)
            && $stable(frame_timestamp) && $stable(last_of_run))
        else $error("stalled record changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (record_kind == fwd_pkg::KIND_SAMPLE)
            || (record_kind == fwd_pkg::KIND_TRAILER)
            || (record_kind == fwd_pkg::KIND_BAD))
        else $error("unknown record kind");

    // Trailer and bad-word records close their run.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (record_kind != fwd_pkg::KIND_SAMPLE) |-> last_of_run)
        else $error("trailer or bad-word record not marked last");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (record_kind == fwd_pkg::KIND_BAD) |->
            (board_number == 16'd0) && (frame_timestamp == 64'd0)
            && !parity_ok && !count_mismatch)
        else $error("bad-word record carries frame fields");

endmodule

bind frame_word_deframer_top fwd_checker u_fwd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .record_kind     (out_ch.record_kind),
    .board_number    (out_ch.board_number),
    .frame_timestamp (out_ch.frame_timestamp),
    .parity_ok       (out_ch.parity_ok),
    .count_mismatch  (out_ch.count_mismatch),
    .last_of_run     (out_ch.last_of_run)
);
